// ===== sv/mgre_pkg.sv =====
// ----------------------------------------------------------------------------
// Minority game round engine package
// Shared types and constants: operation codes, register indexes and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mgre_pkg;

  localparam int RND_W  = 17;
  localparam int CNT_W  = 9;
  localparam int HIST_W = 11;
  localparam int PAT_W  = 11;
  localparam int AGT_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SET     = 2'd1,
    OP_DECIDE  = 2'd2,
    OP_RESOLVE = 2'd3
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGENTS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRATS  = 2'd2;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic load_bit;
    logic set_hist;
    logic dec_start;
    logic scan_rd;
    logic scan_cmp;
    logic div_start;
    logic div_step;
    logic pick_rd;
    logic pick_cmp;
    logic bit_rd;
    logic bit_wb;
    logic res_start;
    logic res_rd_pick;
    logic res_rd_score;
    logic res_wr;
    logic res_end;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic clr_last;
    logic agent_ok;
    logic l_last;
    logic div_last;
    logic pick_hit;
    logic res_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/mgre_if.sv =====
// ----------------------------------------------------------------------------
// Minority game channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mgre_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  agent_index;
  logic        strategy_index;
  logic [10:0] pattern;
  logic        action_bit;
  logic [16:0] tie_random;

  modport source (output valid, operation, agent_index, strategy_index, pattern,
                  action_bit, tie_random, input ready);
  modport sink (input valid, operation, agent_index, strategy_index, pattern,
                action_bit, tie_random, output ready);
endinterface

interface mgre_result_if;
  logic        valid;
  logic        ready;
  logic        chosen_strategy;
  logic        chosen_action;
  logic [8:0]  count_zero;
  logic [8:0]  count_one;
  logic        winner;
  logic [10:0] history_now;

  modport source (output valid, chosen_strategy, chosen_action, count_zero,
                  count_one, winner, history_now, input ready);
  modport sink (input valid, chosen_strategy, chosen_action, count_zero,
                count_one, winner, history_now, output ready);
endinterface

// ===== sv/mgre_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mgre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ===== sv/mgre_datapath.sv =====
// ----------------------------------------------------------------------------
// Minority game datapath
// Configuration, item and round registers, the strategy, score and pick
// memories, the best-score scan, the tie modulo unit and the score updates.
// ----------------------------------------------------------------------------
module mgre_datapath #(
  parameter int MAX_AGENTS       = 256,
  parameter int MAX_STRATEGIES   = 2,
  parameter int MAX_HISTORY_BITS = 11,
  parameter int SCORE_BITS       = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mgre_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mgre_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]                   operation_i,
  input  logic [7:0]                   agent_index_i,
  input  logic                         strategy_index_i,
  input  logic [10:0]                  pattern_i,
  input  logic                         action_bit_i,
  input  logic [16:0]                  tie_random_i,
  input  mgre_pkg::ctrl_cmd_t          cmd_i,
  output mgre_pkg::dp_stat_t           stat_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         chosen_strategy_o,
  output logic                         chosen_action_o,
  output logic [8:0]                   count_zero_o,
  output logic [8:0]                   count_one_o,
  output logic                         winner_o,
  output logic [10:0]                  history_now_o
);
  import mgre_pkg::*;

  localparam int AW  = $clog2(MAX_AGENTS);
  localparam int SW  = (MAX_STRATEGIES > 1) ? $clog2(MAX_STRATEGIES) : 1;
  localparam int TW  = $clog2(MAX_STRATEGIES + 1);
  localparam int HW  = MAX_HISTORY_BITS;
  localparam int NW  = AW + 1;
  localparam int SD  = MAX_AGENTS * MAX_STRATEGIES;
  localparam int SDW = $clog2(SD);
  localparam int BD  = SD * (2 ** HW);
  localparam int BDW = $clog2(BD);
  localparam int PW  = SW + 1;
  localparam int DCW = $clog2(RND_W);
  localparam logic signed [SCORE_BITS-1:0] SMAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SMIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  function automatic logic [BDW-1:0] bit_addr(input int a, input int st,
                                              input logic [HW-1:0] p);
    longint row;
    row = longint'(a) * MAX_STRATEGIES + longint'(st);
    return BDW'((row * (longint'(1) <<< HW)) + longint'(p));
  endfunction

  function automatic logic signed [SCORE_BITS-1:0] sat_step(
      input logic signed [SCORE_BITS-1:0] v, input logic up);
    logic signed [SCORE_BITS-1:0] r;
    r = v;
    if (up && v != SMAX) r = v + 1'b1;
    else if (!up && v != SMIN) r = v - 1'b1;
    return r;
  endfunction

  // Configuration registers and their clamped values.
  logic [3:0] mem_len_q;
  logic [8:0] agents_q;
  logic [1:0] strats_q;
  logic [NW-1:0] n_eff;
  logic [TW-1:0] s_eff;
  logic [HW-1:0] mask;
  int            m_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_len_q <= 4'd11;
      agents_q  <= 9'd256;
      strats_q  <= 2'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MEM_LEN: mem_len_q <= cfg_data_i[3:0];
        CFG_AGENTS:  agents_q  <= cfg_data_i;
        CFG_STRATS:  strats_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (agents_q == '0) n_eff = NW'(1);
    else if (int'(agents_q) > MAX_AGENTS) n_eff = NW'(MAX_AGENTS);
    else n_eff = NW'(agents_q);
    if (strats_q == '0) s_eff = TW'(1);
    else if (int'(strats_q) > MAX_STRATEGIES) s_eff = TW'(MAX_STRATEGIES);
    else s_eff = TW'(strats_q);
    if (mem_len_q == '0) m_eff = 1;
    else if (int'(mem_len_q) > HW) m_eff = HW;
    else m_eff = int'(mem_len_q);
    mask = HW'((33'd1 << m_eff) - 33'd1);
  end

  // Item and round state.
  op_e                          op_q;
  logic [7:0]                   agent_q;
  logic                         sidx_q;
  logic [10:0]                  pat_q;
  logic                         abit_q;
  logic [RND_W-1:0]             rnd_q;
  logic [HW-1:0]                hist_q;
  logic [CNT_W-1:0]             cnt0_q, cnt1_q;
  logic [TW-1:0]                l_q, ties_q, rem_q, seen_q;
  logic signed [SCORE_BITS-1:0] best_q;
  logic [RND_W-1:0]             rnd_sh_q;
  logic [DCW-1:0]               div_cnt_q;
  logic [SW-1:0]                pick_q;
  logic [AW-1:0]                idx_q;
  logic                         win_q;
  logic                         r_strat_q, r_act_q, r_win_q;
  logic [CNT_W-1:0]             r_cnt0_q, r_cnt1_q;
  logic [SDW-1:0]               clr_q;
  logic                         out_valid_q;

  // Memory ports.
  logic                         sc_we, sc_re;
  logic [SDW-1:0]               sc_waddr, sc_raddr, scan_addr, res_addr;
  logic [SCORE_BITS-1:0]        sc_wdata, sc_rdata;
  logic signed [SCORE_BITS-1:0] sc_val;
  logic                         pk_we, pk_re;
  logic [AW-1:0]                pk_waddr;
  logic [PW-1:0]                pk_wdata, pk_rdata;
  logic                         bt_we, bt_re, bt_rdata;
  logic [BDW-1:0]               bt_waddr, bt_raddr;
  logic [SW-1:0]                res_st;
  logic                         load_ok;
  logic [TW:0]                  div_r2;

  assign sc_val    = signed'(sc_rdata);
  assign scan_addr = SDW'(int'(agent_q) * MAX_STRATEGIES + int'(l_q));
  assign res_st    = (int'(pk_rdata[PW-1:1]) < MAX_STRATEGIES) ? pk_rdata[PW-1:1] : '0;
  assign res_addr  = SDW'(int'(idx_q) * MAX_STRATEGIES + int'(res_st));
  assign load_ok   = (int'(agent_q) < MAX_AGENTS) && (int'(sidx_q) < MAX_STRATEGIES);
  assign div_r2    = {rem_q, rnd_sh_q[RND_W-1]};

  always_comb begin
    sc_we    = cmd_i.clr_step | cmd_i.res_wr;
    sc_waddr = cmd_i.clr_step ? clr_q : res_addr;
    sc_wdata = cmd_i.clr_step ? '0 : sat_step(sc_val, pk_rdata[0] == win_q);
    sc_re    = cmd_i.scan_rd | cmd_i.pick_rd | cmd_i.res_rd_score;
    sc_raddr = cmd_i.res_rd_score ? res_addr : scan_addr;
    pk_we    = (cmd_i.clr_step && int'(clr_q) < MAX_AGENTS) | cmd_i.bit_wb;
    pk_waddr = cmd_i.clr_step ? AW'(clr_q) : AW'(agent_q);
    pk_wdata = cmd_i.clr_step ? '0 : {pick_q, bt_rdata};
    pk_re    = cmd_i.res_rd_pick;
    bt_we    = cmd_i.load_bit & load_ok;
    bt_waddr = bit_addr(int'(agent_q), int'(sidx_q), HW'(pat_q));
    bt_re    = cmd_i.bit_rd;
    bt_raddr = bit_addr(int'(agent_q), int'(pick_q), hist_q & mask);
  end

  mgre_ram #(.WIDTH(SCORE_BITS), .DEPTH(SD)) u_score_ram (
    .clk_i, .we_i(sc_we), .waddr_i(sc_waddr), .wdata_i(sc_wdata),
    .re_i(sc_re), .raddr_i(sc_raddr), .rdata_o(sc_rdata)
  );

  mgre_ram #(.WIDTH(PW), .DEPTH(MAX_AGENTS)) u_pick_ram (
    .clk_i, .we_i(pk_we), .waddr_i(pk_waddr), .wdata_i(pk_wdata),
    .re_i(pk_re), .raddr_i(idx_q), .rdata_o(pk_rdata)
  );

  mgre_ram #(.WIDTH(1), .DEPTH(BD)) u_bit_ram (
    .clk_i, .we_i(bt_we), .waddr_i(bt_waddr), .wdata_i(abit_q),
    .re_i(bt_re), .raddr_i(bt_raddr), .rdata_o(bt_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      hist_q      <= HW'(3);
      cnt0_q      <= '0;
      cnt1_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.set_hist) hist_q <= HW'(pat_q) & mask;
      if (cmd_i.res_end) begin
        hist_q <= HW'({hist_q, win_q}) & mask;
        cnt0_q <= '0;
        cnt1_q <= '0;
      end
      if (cmd_i.bit_wb) begin
        if (bt_rdata) begin
          if (cnt1_q != CNT_MAX) cnt1_q <= cnt1_q + 1'b1;
        end else begin
          if (cnt0_q != CNT_MAX) cnt0_q <= cnt0_q + 1'b1;
        end
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_e'(operation_i);
      agent_q   <= agent_index_i;
      sidx_q    <= strategy_index_i;
      pat_q     <= pattern_i;
      abit_q    <= action_bit_i;
      rnd_q     <= tie_random_i;
      r_strat_q <= 1'b0;
      r_act_q   <= 1'b0;
      r_win_q   <= 1'b0;
    end
    // The strategy counter restarts for the scan and again for the pick.
    if (cmd_i.dec_start || cmd_i.div_start) l_q <= '0;
    else if (cmd_i.scan_cmp || cmd_i.pick_cmp) l_q <= l_q + 1'b1;
    if (cmd_i.scan_cmp) begin
      if (l_q == '0 || sc_val > best_q) begin
        best_q <= sc_val;
        ties_q <= TW'(1);
      end else if (sc_val == best_q) begin
        ties_q <= ties_q + 1'b1;
      end
    end
    if (cmd_i.div_start) begin
      rem_q     <= '0;
      rnd_sh_q  <= rnd_q;
      div_cnt_q <= '0;
      seen_q    <= '0;
    end
    if (cmd_i.div_step) begin
      // One restoring step of the tie modulo per cycle.
      if (div_r2 >= {1'b0, ties_q}) rem_q <= TW'(div_r2 - {1'b0, ties_q});
      else rem_q <= TW'(div_r2);
      rnd_sh_q  <= rnd_sh_q << 1;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
    if (cmd_i.pick_cmp) begin
      if (sc_val == best_q) begin
        seen_q <= seen_q + 1'b1;
        if (seen_q == rem_q) pick_q <= SW'(l_q);
      end
    end
    if (cmd_i.bit_wb) begin
      r_strat_q <= pick_q[0];
      r_act_q   <= bt_rdata;
    end
    if (cmd_i.res_start) begin
      win_q <= (cnt0_q < cnt1_q) ? 1'b0 : 1'b1;
      idx_q <= '0;
    end
    if (cmd_i.res_wr) idx_q <= idx_q + 1'b1;
    if (cmd_i.res_end) begin
      r_cnt0_q <= cnt0_q;
      r_cnt1_q <= cnt1_q;
      r_win_q  <= win_q;
    end
    if (cmd_i.out_load) begin
      chosen_strategy_o <= r_strat_q;
      chosen_action_o   <= r_act_q;
      count_zero_o      <= (op_q == OP_RESOLVE) ? r_cnt0_q : cnt0_q;
      count_one_o       <= (op_q == OP_RESOLVE) ? r_cnt1_q : cnt1_q;
      winner_o          <= r_win_q;
      history_now_o     <= HIST_W'(hist_q);
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o.op       = op_q;
    stat_o.clr_last = (int'(clr_q) == SD - 1);
    stat_o.agent_ok = (NW'(agent_q) < n_eff) && (int'(agent_q) < MAX_AGENTS);
    stat_o.l_last   = (l_q == s_eff - 1'b1);
    stat_o.div_last = (int'(div_cnt_q) == RND_W - 1);
    stat_o.pick_hit = (sc_val == best_q) && (seen_q == rem_q);
    stat_o.res_last = (NW'(idx_q) == n_eff - 1'b1);
    stat_o.out_free = !out_valid_q || out_ready_i;
  end
endmodule

// ===== sv/mgre_ctrl.sv =====
// ----------------------------------------------------------------------------
// Minority game controller
// Sequences the clearing pass, loads, sets, the decide scan, modulo and pick,
// the resolve walk and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module mgre_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mgre_pkg::dp_stat_t  stat_i,
  output mgre_pkg::ctrl_cmd_t cmd_o
);
  import mgre_pkg::*;

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_EXEC     = 14'b00000000000100,
    S_DEC_RD   = 14'b00000000001000,
    S_DEC_CMP  = 14'b00000000010000,
    S_DIV      = 14'b00000000100000,
    S_PICK_RD  = 14'b00000001000000,
    S_PICK_CMP = 14'b00000010000000,
    S_BIT_RD   = 14'b00000100000000,
    S_BIT_WB   = 14'b00001000000000,
    S_RES_P    = 14'b00010000000000,
    S_RES_S    = 14'b00100000000000,
    S_RES_W    = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   res_end_pending_q, res_end_pending_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_CLEAR;
      res_end_pending_q <= 1'b0;
    end else begin
      state_q           <= state_d;
      res_end_pending_q <= res_end_pending_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    res_end_pending_d = 1'b0;
    cmd_o             = '0;
    in_ready_o        = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.op)
          OP_LOAD: begin
            cmd_o.load_bit = 1'b1;
            state_d = S_FIN;
          end
          OP_SET: begin
            cmd_o.set_hist = 1'b1;
            state_d = S_FIN;
          end
          OP_DECIDE: begin
            if (stat_i.agent_ok) begin
              cmd_o.dec_start = 1'b1;
              state_d = S_DEC_RD;
            end else begin
              state_d = S_FIN;
            end
          end
          default: begin
            cmd_o.res_start = 1'b1;
            state_d = S_RES_P;
          end
        endcase
      end
      S_DEC_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_DEC_CMP;
      end
      S_DEC_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        if (stat_i.l_last) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_DEC_RD;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_PICK_RD;
      end
      S_PICK_RD: begin
        cmd_o.pick_rd = 1'b1;
        state_d = S_PICK_CMP;
      end
      S_PICK_CMP: begin
        cmd_o.pick_cmp = 1'b1;
        state_d = stat_i.pick_hit ? S_BIT_RD : S_PICK_RD;
      end
      S_BIT_RD: begin
        cmd_o.bit_rd = 1'b1;
        state_d = S_BIT_WB;
      end
      S_BIT_WB: begin
        cmd_o.bit_wb = 1'b1;
        state_d = S_FIN;
      end
      S_RES_P: begin
        cmd_o.res_rd_pick = 1'b1;
        state_d = S_RES_S;
      end
      S_RES_S: begin
        cmd_o.res_rd_score = 1'b1;
        state_d = S_RES_W;
      end
      S_RES_W: begin
        cmd_o.res_wr = 1'b1;
        if (stat_i.res_last) begin
          res_end_pending_d = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_RES_P;
        end
      end
      S_FIN: begin
        // The round wrap-up happens once, on the first cycle after the walk.
        cmd_o.res_end = res_end_pending_q;
        if (!res_end_pending_q && stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ===== sv/minority_game_round_engine.sv =====
// ----------------------------------------------------------------------------
// Minority game round engine
// Agents pick their best strategy, vote a side and get scored each round.
//
//   channel   direction  carries
//   in_i      sink       one operation: load, set history, decide, resolve
//   out_o     source     one result per item
//   cfg_*     write      memory length, agents in use, strategies in use
//
// Decide is paced by the score memory's single read port and the 17-step
// modulo; resolve makes one score update per agent. After reset a clearing
// pass zeroes the scores and picks; no item is taken meanwhile. A stalled
// output holds the finished item while the next item is already accepted.
// ----------------------------------------------------------------------------
module minority_game_round_engine #(
  parameter int MAX_AGENTS       = 256,
  parameter int MAX_STRATEGIES   = 2,
  parameter int MAX_HISTORY_BITS = 11,
  parameter int SCORE_BITS       = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mgre_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mgre_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mgre_item_if.sink                       in_i,
  mgre_result_if.source                   out_o
);
  import mgre_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mgre_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .stat_i(stat), .cmd_o(cmd)
  );

  mgre_datapath #(
    .MAX_AGENTS(MAX_AGENTS), .MAX_STRATEGIES(MAX_STRATEGIES),
    .MAX_HISTORY_BITS(MAX_HISTORY_BITS), .SCORE_BITS(SCORE_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .operation_i(in_i.operation), .agent_index_i(in_i.agent_index),
    .strategy_index_i(in_i.strategy_index), .pattern_i(in_i.pattern),
    .action_bit_i(in_i.action_bit), .tie_random_i(in_i.tie_random),
    .cmd_i(cmd), .stat_o(stat),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .chosen_strategy_o(out_o.chosen_strategy), .chosen_action_o(out_o.chosen_action),
    .count_zero_o(out_o.count_zero), .count_one_o(out_o.count_one),
    .winner_o(out_o.winner), .history_now_o(out_o.history_now)
  );
endmodule

// ===== sv/mgre_checker.sv =====
// ----------------------------------------------------------------------------
// Minority game port checker
// Watches the result channel for consistency between its fields over time.
// ----------------------------------------------------------------------------
module mgre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        chosen_strategy,
  input logic        chosen_action,
  input logic [8:0]  count_one,
  input logic        winner,
  input logic [10:0] history_now
);
  // A stalled result item must keep its history and side-one count.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(history_now) && $stable(count_one))
    else $error("result changed while stalled");

  // A resolve result that names side one as winner carries no agent choice.
  a_resolve_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && winner |-> !chosen_strategy && !chosen_action)
    else $error("resolve result carries a choice");

  // The newest history bit is the winner of the round just resolved, checked when side one wins.
  a_hist_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && winner |-> history_now[0])
    else $error("winner not shifted into history");

  // A decide on side one has counted at least that agent.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && chosen_action |-> count_one != 9'd0)
    else $error("side one vote not counted");
endmodule

bind minority_game_round_engine mgre_checker u_mgre_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .chosen_strategy(out_o.chosen_strategy), .chosen_action(out_o.chosen_action),
  .count_one(out_o.count_one), .winner(out_o.winner),
  .history_now(out_o.history_now)
);

// ===== sim/mgre_tb_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel types
// Field groups for one operation item and one result item, used by the
// sequence generator, the scoreboard and the driver.
// ----------------------------------------------------------------------------
package mgre_tb_pkg;
  import mgre_pkg::*;

  typedef struct {
    op_e         op;
    logic [7:0]  agent;
    logic        strat;
    logic [10:0] pat;
    logic        abit;
    logic [16:0] rnd;
  } op_item_t;

  typedef struct {
    logic        strat;
    logic        act;
    logic [8:0]  cnt0;
    logic [8:0]  cnt1;
    logic        win;
    logic [10:0] hist;
  } round_result_t;
endpackage

// ===== sim/minority_game_round_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Minority game round engine testbench
// Drives load, set, decide and resolve items through the engine under
// several register settings, predicts each result from a private copy of
// the agent tables, scores and counts, and checks results in order.
// ----------------------------------------------------------------------------
module minority_game_round_engine_tb;
  import mgre_pkg::*;
  import mgre_tb_pkg::*;

  localparam int RUN_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  mgre_item_if itm ();
  mgre_result_if res ();

  minority_game_round_engine u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_i(itm), .out_o(res)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state.
  bit          tbl_bits[1 << 20];
  bit          tbl_written[1 << 20];
  int          scores[512];
  bit          pick_s[256];
  bit          pick_a[256];
  int          side0, side1;
  logic [10:0] hist;
  logic [3:0]  mem_len;
  logic [8:0]  n_agents;
  logic [1:0]  n_strats;

  op_item_t      pending_ops[$];
  round_result_t expected_results[$];
  int errors = 0;
  int issued = 0;
  bit in_taken = 1'b0;
  int cycles = 0;

  function automatic int bit_addr(int agent, int s, int pat);
    return ((agent * 2 + s) << 11) | (pat & 11'h7ff);
  endfunction

  function automatic int hist_mask();
    int m;
    m = (mem_len < 1) ? 1 : (mem_len > 11) ? 11 : mem_len;
    return (1 << m) - 1;
  endfunction

  function automatic round_result_t play_item(op_item_t it);
    round_result_t r;
    int n, s, base, best, ties, k, seen, pick, i, st;
    bit w;
    n = (n_agents < 1) ? 1 : (n_agents > 256) ? 256 : n_agents;
    s = (n_strats < 1) ? 1 : (n_strats > 2) ? 2 : n_strats;
    r = '{1'b0, 1'b0, side0[8:0], side1[8:0], 1'b0, 11'd0};
    case (it.op)
      OP_LOAD: begin
        tbl_bits[bit_addr(it.agent, it.strat, it.pat)] = it.abit;
        tbl_written[bit_addr(it.agent, it.strat, it.pat)] = 1'b1;
      end
      OP_SET: hist = it.pat & hist_mask();
      OP_DECIDE: begin
        if (it.agent < n) begin
          base = it.agent * 2;
          best = scores[base];
          ties = 1;
          for (i = 1; i < s; i++) begin
            if (scores[base + i] > best) begin
              best = scores[base + i];
              ties = 1;
            end else if (scores[base + i] == best) begin
              ties++;
            end
          end
          k = it.rnd % ties;
          seen = 0;
          pick = 0;
          for (i = 0; i < s; i++) begin
            if (scores[base + i] == best) begin
              if (seen == k) begin
                pick = i;
                break;
              end
              seen++;
            end
          end
          r.strat = pick[0];
          r.act = tbl_bits[bit_addr(it.agent, pick, hist & hist_mask())];
          pick_s[it.agent] = r.strat;
          pick_a[it.agent] = r.act;
          if (r.act) begin
            if (side1 < 511) side1++;
          end else begin
            if (side0 < 511) side0++;
          end
          r.cnt0 = side0[8:0];
          r.cnt1 = side1[8:0];
        end
      end
      default: begin
        w = (side0 < side1) ? 1'b0 : 1'b1;
        r.win = w;
        for (i = 0; i < n; i++) begin
          st = i * 2 + pick_s[i];
          if (pick_a[i] == w) begin
            if (scores[st] < 32767) scores[st]++;
          end else begin
            if (scores[st] > -32768) scores[st]--;
          end
        end
        hist = ((hist << 1) | w) & hist_mask();
        side0 = 0;
        side1 = 0;
      end
    endcase
    r.hist = hist;
    return r;
  endfunction

  task automatic push_item(op_e op, int agent, int s, int pat, int abit, int rnd);
    op_item_t it;
    it = '{op, agent[7:0], s[0], pat[10:0], abit[0], rnd[16:0]};
    pending_ops.push_back(it);
    expected_results.push_back(play_item(it));
    issued++;
  endtask

  // A decide may read the table bit of any strategy in use; any such bit not yet
  // loaded gets a load item with a random value first.
  task automatic add_item(op_e op, int agent, int s, int pat, int abit, int rnd);
    int ns, a;
    ns = (n_strats < 1) ? 1 : (n_strats > 2) ? 2 : n_strats;
    if (op == OP_DECIDE && agent < ((n_agents < 1) ? 1 : n_agents)) begin
      for (int l = 0; l < ns; l++) begin
        a = bit_addr(agent, l, hist & hist_mask());
        if (!tbl_written[a])
          push_item(OP_LOAD, agent, l, hist & hist_mask(), $urandom_range(0, 1), 0);
      end
    end
    push_item(op, agent, s, pat, abit, rnd);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[8:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MEM_LEN: mem_len = value[3:0];
      CFG_AGENTS: n_agents = value[8:0];
      default: n_strats = value[1:0];
    endcase
  endtask

  task automatic drain();
    wait (pending_ops.size() == 0 && !itm.valid && expected_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(int m, int n, int s);
    drain();
    write_reg(CFG_MEM_LEN, m);
    write_reg(CFG_AGENTS, n);
    write_reg(CFG_STRATS, s);
  endtask

  // Rounds of decides with random content, sprinkled with loads, history
  // sets and stray agents, each closed by a resolve.
  task automatic play_rounds(int rounds);
    int n, d;
    n = (n_agents < 1) ? 1 : (n_agents > 256) ? 256 : n_agents;
    for (int r = 0; r < rounds; r++) begin
      d = $urandom_range(1, (n < 12) ? n + 2 : 14);
      for (int j = 0; j < d; j++) begin
        case ($urandom_range(0, 9))
          0: add_item(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 1),
                      $urandom_range(0, 2047), $urandom_range(0, 1), $urandom);
          1: add_item(OP_SET, $urandom, $urandom, $urandom_range(0, 2047),
                      $urandom, $urandom);
          2: add_item(OP_DECIDE, $urandom_range(0, 255), $urandom, $urandom,
                      $urandom, $urandom_range(0, 131071));
          default: add_item(OP_DECIDE, $urandom_range(0, n - 1), $urandom, $urandom,
                            $urandom, $urandom_range(0, 131071));
        endcase
      end
      add_item(OP_RESOLVE, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    side0 = 0;
    side1 = 0;
    hist = 11'd3;
    mem_len = 4'd11;
    n_agents = 9'd256;
    n_strats = 2'd2;
    foreach (scores[i]) scores[i] = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes at the reset settings.
    add_item(OP_LOAD, 255, 1, 2047, 1, 0);
    add_item(OP_LOAD, 0, 0, 0, 0, 131071);
    add_item(OP_SET, 0, 0, 2047, 0, 0);
    add_item(OP_DECIDE, 255, 0, 0, 0, 131071);
    add_item(OP_DECIDE, 0, 1, 2047, 1, 0);
    add_item(OP_DECIDE, 128, 0, 0, 0, 1);
    add_item(OP_RESOLVE, 0, 0, 0, 0, 0);
    add_item(OP_DECIDE, 255, 0, 0, 0, 0);
    add_item(OP_DECIDE, 255, 0, 0, 0, 1);
    add_item(OP_RESOLVE, 255, 1, 2047, 1, 131071);
    add_item(OP_SET, 255, 1, 12'h5a5, 1, 131071);

    // Registers below range clamp up: one agent, one strategy, one bit.
    set_regs(0, 0, 0);
    add_item(OP_DECIDE, 0, 0, 0, 0, 5);
    add_item(OP_DECIDE, 1, 0, 0, 0, 5);
    add_item(OP_SET, 0, 0, 2047, 0, 0);
    add_item(OP_RESOLVE, 0, 0, 0, 0, 0);

    // Side count saturation: one agent decides over and over in one round.
    set_regs(1, 1, 1);
    for (int i = 0; i < 515; i++)
      add_item(OP_DECIDE, 0, 0, 0, 0, $urandom_range(0, 131071));
    add_item(OP_RESOLVE, 0, 0, 0, 0, 0);

    // Registers above range clamp down.
    set_regs(15, 511, 3);
    play_rounds(2);
    set_regs(11, 256, 2);
    play_rounds(1);

    while (issued < 1900) begin
      set_regs($urandom_range(0, 15),
               ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
                                           : $urandom_range(1, 16),
               $urandom_range(0, 3));
      play_rounds($urandom_range(8, 30));
    end
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Sender: bursts of items separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) in_taken <= itm.valid && itm.ready;

  always @(negedge clk_i) begin
    op_item_t it;
    bit next_v;
    next_v = itm.valid && !in_taken;
    if (rst_ni && !next_v) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        it = pending_ops.pop_front();
        itm.operation <= it.op;
        itm.agent_index <= it.agent;
        itm.strategy_index <= it.strat;
        itm.pattern <= it.pat;
        itm.action_bit <= it.abit;
        itm.tie_random <= it.rnd;
        next_v = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
    itm.valid <= next_v;
  end

  initial begin
    itm.valid = 1'b0;
    itm.operation = OP_LOAD;
    itm.agent_index = '0;
    itm.strategy_index = 1'b0;
    itm.pattern = '0;
    itm.action_bit = 1'b0;
    itm.tie_random = '0;
    res.ready = 1'b0;
  end

  // Receiver: the stall style (none, short or long stalls) is picked anew at random.
  int stall_left = 0;
  int stall_mode = 0;

  always @(negedge clk_i) begin
    if (cycles % 300 == 0) stall_mode = $urandom_range(0, 2);
    if (stall_left > 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      if (stall_mode == 1 && $urandom_range(0, 1) == 1)
        stall_left = $urandom_range(1, 3);
      else if (stall_mode == 2 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(5, 60);
    end
  end

  always @(posedge clk_i) begin
    round_result_t e;
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_ni && res.valid && res.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %0d %0d %0d %0d %0d %0h",
                 $time, res.chosen_strategy, res.chosen_action, res.count_zero,
                 res.count_one, res.winner, res.history_now);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (res.chosen_strategy !== e.strat) begin
          $display("%0t: chosen_strategy expected %0d actual %0d", $time, e.strat,
                   res.chosen_strategy);
          errors++;
        end
        if (res.chosen_action !== e.act) begin
          $display("%0t: chosen_action expected %0d actual %0d", $time, e.act,
                   res.chosen_action);
          errors++;
        end
        if (res.count_zero !== e.cnt0) begin
          $display("%0t: count_zero expected %0d actual %0d", $time, e.cnt0,
                   res.count_zero);
          errors++;
        end
        if (res.count_one !== e.cnt1) begin
          $display("%0t: count_one expected %0d actual %0d", $time, e.cnt1,
                   res.count_one);
          errors++;
        end
        if (res.winner !== e.win) begin
          $display("%0t: winner expected %0d actual %0d", $time, e.win, res.winner);
          errors++;
        end
        if (res.history_now !== e.hist) begin
          $display("%0t: history_now expected %0h actual %0h", $time, e.hist,
                   res.history_now);
          errors++;
        end
      end
    end
  end
endmodule
